>>> hw/rtl/swm_pkg.sv
package swm_pkg;

  // default sizing of the window and the sample
  localparam int unsigned WINDOW_MAX_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  // width of the window size register
  localparam int unsigned WIN_CFG_W = 7;

  // commands from the controller to the datapath
  typedef struct packed {
    logic insert;    // take the input word into ring and sorted cells
    logic med_load;  // load the median into the output register, read oldest
    logic remove;    // drop the oldest sample from the sorted cells
  } swm_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;      // the word being inserted fills the window
  } swm_status_t;

endpackage

>>> hw/rtl/swm_ram.sv
module swm_ram import swm_pkg::*; #(
  parameter int unsigned WIDTH = SAMPLE_BITS_DEF,
  parameter int unsigned DEPTH = WINDOW_MAX_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/swm_ctrl.sv
module swm_ctrl import swm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  swm_status_t status_i,
  output swm_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEDIAN,
    ST_REMOVE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   med_go;

  assign in_acc = in_valid_i && (state_q == ST_IDLE);
  assign med_go = (state_q == ST_MEDIAN) && !(out_valid_q && out_stall_i);

  // next state and output valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && status_i.full) begin
          state_d = ST_MEDIAN;
        end
      end
      ST_MEDIAN: begin
        if (med_go) begin
          state_d     = ST_REMOVE;
          out_valid_d = 1'b1;
        end
      end
      ST_REMOVE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign cmd_o.insert    = in_acc;
  assign cmd_o.med_load  = med_go;
  assign cmd_o.remove    = (state_q == ST_REMOVE);

`ifndef SYNTH
  // removal always follows a median load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REMOVE) |-> $past(state_q == ST_MEDIAN))
    else $error("remove without median");

  // a held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MEDIAN && out_valid_q && out_stall_i) |=> (state_q == ST_MEDIAN))
    else $error("median loaded over stalled word");

  // a median load raises output valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.med_load |=> out_valid_q)
    else $error("output valid missing after median load");
`endif

endmodule

>>> hw/rtl/swm_datapath.sv
module swm_datapath import swm_pkg::*; #(
  parameter int unsigned WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [WIN_CFG_W-1:0]          cfg_wdata_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          restart_i,
  input  swm_cmd_t                      cmd_i,
  output swm_status_t                   status_o,
  output logic signed [SAMPLE_BITS:0]   median_doubled_o
);

  localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CMP_W = (CNT_W > WIN_CFG_W) ? CNT_W : WIN_CFG_W;
  localparam logic [WIN_CFG_W-1:0] WIN_RESET = WIN_CFG_W'(3);

  logic [WIN_CFG_W-1:0]          win_q;
  logic [CNT_W-1:0]              fill_q, fill_d;
  logic [IDX_W-1:0]              oldest_q, oldest_d;
  logic signed [SAMPLE_BITS-1:0] cell_q [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] cell_d [WINDOW_MAX];
  logic signed [SAMPLE_BITS:0]   med_q;

  logic [CMP_W-1:0]              win_ext;
  logic [CNT_W-1:0]              eff_w;
  logic [CNT_W-1:0]              fill_base;
  logic [IDX_W-1:0]              oldest_base;
  logic [CNT_W:0]                wr_sum;
  logic [IDX_W-1:0]              wr_addr;
  logic [CNT_W-1:0]              lo_idx, hi_idx;
  logic signed [SAMPLE_BITS-1:0] leave;
  logic [WINDOW_MAX-1:0]         ins_gt;
  logic [WINDOW_MAX-1:0]         rem_le;

  // effective window, clamped to one .. WINDOW_MAX
  assign win_ext = CMP_W'(win_q);
  always_comb begin
    if (win_ext == '0) begin
      eff_w = CNT_W'(1);
    end else if (win_ext > CMP_W'(WINDOW_MAX)) begin
      eff_w = CNT_W'(WINDOW_MAX);
    end else begin
      eff_w = CNT_W'(win_ext);
    end
  end

  // window emptied by restart or by a stale full window
  assign fill_base   = (restart_i || fill_q >= eff_w) ? '0 : fill_q;
  assign oldest_base = (restart_i || fill_q >= eff_w) ? '0 : oldest_q;
  assign status_o.full = ((CNT_W+1)'(fill_base) + (CNT_W+1)'(1)) >= (CNT_W+1)'(eff_w);

  // ring write address with wrap
  always_comb begin
    wr_sum = (CNT_W+1)'(oldest_base) + (CNT_W+1)'(fill_base);
    if (wr_sum >= (CNT_W+1)'(WINDOW_MAX)) begin
      wr_sum = wr_sum - (CNT_W+1)'(WINDOW_MAX);
    end
    wr_addr = wr_sum[IDX_W-1:0];
  end

  swm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX),
    .ADDR_W(IDX_W)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.insert),
    .waddr_i(wr_addr),
    .wdata_i(sample_i),
    .raddr_i(oldest_q),
    .rdata_o(leave)
  );

  // per cell compares, valid cells set by the fill count
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      ins_gt[i] = (CNT_W'(i) >= fill_base) || (cell_q[i] > sample_i);
      rem_le[i] = (CNT_W'(i) < fill_q) && (cell_q[i] <= leave);
    end
  end

  // sorted cells: shift up on insert, shift down on remove
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      cell_d[i] = cell_q[i];
      if (cmd_i.insert) begin
        if (i > 0 && ins_gt[(i > 0) ? i - 1 : 0]) begin
          cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
        end else if (ins_gt[i]) begin
          cell_d[i] = sample_i;
        end
      end else if (cmd_i.remove && (i + 1 < WINDOW_MAX)) begin
        if (!rem_le[(i + 1 < WINDOW_MAX) ? i + 1 : i]) begin
          cell_d[i] = cell_q[(i + 1 < WINDOW_MAX) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      cell_q[i] <= cell_d[i];
    end
  end

  // counters
  always_comb begin
    fill_d   = fill_q;
    oldest_d = oldest_q;
    if (cfg_we_i) begin
      fill_d   = '0;
      oldest_d = '0;
    end else if (cmd_i.insert) begin
      fill_d   = fill_base + CNT_W'(1);
      oldest_d = oldest_base;
    end else if (cmd_i.remove) begin
      fill_d = fill_q - CNT_W'(1);
      if ((CNT_W+1)'(oldest_q) + (CNT_W+1)'(1) >= (CNT_W+1)'(WINDOW_MAX)) begin
        oldest_d = '0;
      end else begin
        oldest_d = oldest_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= WIN_RESET;
      fill_q   <= '0;
      oldest_q <= '0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
    end
  end

  // median: sum of the two middle cells, equal for an odd window
  assign lo_idx = (eff_w - CNT_W'(1)) >> 1;
  assign hi_idx = eff_w >> 1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.med_load) begin
      med_q <= (SAMPLE_BITS+1)'(cell_q[lo_idx[IDX_W-1:0]])
             + (SAMPLE_BITS+1)'(cell_q[hi_idx[IDX_W-1:0]]);
    end
  end

  assign median_doubled_o = med_q;

`ifndef SYNTH
  // fill count never passes the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW_MAX))
    else $error("fill count overflow");

  // remove only from a full window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.remove |-> (fill_q == eff_w))
    else $error("remove from a window that is not full");

  // median only taken from a full window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.med_load |-> (fill_q == eff_w))
    else $error("median of a partial window");
`endif

endmodule

>>> hw/rtl/sliding_window_median_core.sv
// a word that fills the window has its median loaded in the median state after the insert
// with a result a word runs insert, median, remove before the next is taken; without one, insert only
// median waits on a stalled result; rate set by the arrival ring read and shared sorted-cell update
// reset: window size three, window empty; ring and sorted cells are not cleared
// writing the window size empties the window
module sliding_window_median_core import swm_pkg::*; #(
  parameter int unsigned WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [WIN_CFG_W-1:0]          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS:0]   median_doubled_o
);

  swm_cmd_t    cmd;
  swm_status_t status;

  // sequencer
  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // ring, sorted cells and output register
  swm_datapath #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .sample_i        (sample_i),
    .restart_i       (restart_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .median_doubled_o(median_doubled_o)
  );

endmodule

>>> dv/tb_sliding_window_median_core.sv
module tb_sliding_window_median_core;
  import swm_pkg::*;

  localparam int unsigned WMAX = WINDOW_MAX_DEF;
  localparam int unsigned SB   = SAMPLE_BITS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [SB-1:0] sample;
    logic                 restart;
  } word_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [WIN_CFG_W-1:0]   cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [SB-1:0]   sample_i = '0;
  logic                   restart_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [SB:0]     median_doubled_o;

  sliding_window_median_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .sample_i(sample_i), .restart_i(restart_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .median_doubled_o(median_doubled_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [WIN_CFG_W-1:0]  win_reg;
  logic signed [SB-1:0]  ring_q [WMAX];
  logic signed [SB-1:0]  sorted_q [WMAX];
  int unsigned           held;
  int unsigned           oldest;

  word_t               pending_words[$];
  logic signed [SB:0]  medians_due[$];
  int unsigned         err_count = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         accepted_in = 0;

  // stall as seen at the last rising edge
  logic in_stall_o_q = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic int unsigned eff_window();
    if (win_reg == 0) return 1;
    if (win_reg > WMAX) return WMAX;
    return win_reg;
  endfunction

  // model one accepted word, pushing its median if the window fills
  task automatic predict_median(input word_t w);
    int unsigned wn;
    int unsigned i;
    logic signed [SB-1:0] leaving;
    logic signed [SB:0] dbl;
    wn = eff_window();
    if (w.restart || held >= wn) begin
      held = 0;
      oldest = 0;
    end
    ring_q[(oldest + held) % WMAX] = w.sample;
    i = held;
    while (i > 0 && sorted_q[i-1] > w.sample) begin
      sorted_q[i] = sorted_q[i-1];
      i--;
    end
    sorted_q[i] = w.sample;
    held++;
    if (held < wn) return;
    if (wn & 1) dbl = {sorted_q[wn/2][SB-1], sorted_q[wn/2]} <<< 1;
    else dbl = $signed({sorted_q[wn/2-1][SB-1], sorted_q[wn/2-1]})
             + $signed({sorted_q[wn/2][SB-1], sorted_q[wn/2]});
    medians_due.push_back(dbl);
    leaving = ring_q[oldest % WMAX];
    i = 0;
    while (i < held && sorted_q[i] != leaving) i++;
    if (i < held) begin
      while (i + 1 < held) begin
        sorted_q[i] = sorted_q[i+1];
        i++;
      end
    end
    held--;
    oldest = (oldest + 1) % WMAX;
  endtask

  // driver: presents queued words at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o_q) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          sample_i <= pending_words[0].sample;
          restart_i <= pending_words[0].restart;
          void'(pending_words.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: accept at rising edge, check medians
  always @(posedge clk_i) begin
    in_stall_o_q <= in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_median('{sample: sample_i, restart: restart_i});
        accepted_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (medians_due.size() == 0)
          report_mismatch($sformatf("unexpected median %0d", median_doubled_o));
        else begin
          if (median_doubled_o !== medians_due[0])
            report_mismatch($sformatf("median_doubled got %0d want %0d",
                                      median_doubled_o, medians_due[0]));
          void'(medians_due.pop_front());
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else if (in_valid_i || medians_due.size() > 0) quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_sliding_window_median_core: errors");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid_i || medians_due.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WIN_CFG_W-1:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    win_reg = v;
    held = 0;
    oldest = 0;
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(SB'($urandom_range(7))) - 4;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic queue_random(input int unsigned n);
    word_t w;
    for (int k = 0; k < n; k++) begin
      w.sample = rand_sample();
      w.restart = ($urandom_range(49) == 0);
      pending_words.push_back(w);
    end
  endtask

  // stimulus
  initial begin
    logic [WIN_CFG_W-1:0] sizes [10];
    word_t w;
    sizes = '{7'd1, 7'd2, 7'd0, 7'd64, 7'd127, 7'd4, 7'd5, 7'd16, 7'd3, 7'd65};
    win_reg = 7'd3;
    held = 0;
    oldest = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, equal samples, restart mid-window, reset window size
    send_idle_pct = 33;
    recv_idle_pct = 86;
    foreach (sizes[j]) begin end
    w.restart = 1'b0;
    w.sample = 32'sh7fffffff; pending_words.push_back(w);
    pending_words.push_back(w);
    w.sample = 32'sh80000000; pending_words.push_back(w);
    pending_words.push_back(w);
    pending_words.push_back(w);
    w.sample = 0; pending_words.push_back(w);
    w.sample = 5; pending_words.push_back(w);
    w.sample = 5; w.restart = 1'b1; pending_words.push_back(w);
    w.sample = -1; w.restart = 1'b0; pending_words.push_back(w);
    w.sample = -1; pending_words.push_back(w);
    w.sample = 32'sh55555555; pending_words.push_back(w);
    w.sample = 32'shaaaaaaaa; pending_words.push_back(w);
    write_window(7'd2);
    w.sample = 32'sh7fffffff; pending_words.push_back(w);
    pending_words.push_back(w);
    w.sample = 32'sh80000000; pending_words.push_back(w);
    pending_words.push_back(w);

    // random phases over several window sizes
    for (int p = 0; p < 30; p++) begin
      if (p == 10) begin send_idle_pct = 86; recv_idle_pct = 33; end
      if (p == 20) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      if (p % 10 == 5) write_window(7'($urandom_range(127)));
      else if (p % 3 == 0) write_window(sizes[(p / 3) % 10]);
      queue_random((win_reg > 20 && win_reg < 100) ? 60 : 30);
      // pause until all medians are out
      if (p == 7) wait_drained();
    end
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) $display("tb_sliding_window_median_core: clean");
    else $display("tb_sliding_window_median_core: errors");
    $finish;
  end
endmodule
